### sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define HBKD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbkd: assertion failed");

// Clocked assertion that also runs through reset.
`define HBKD_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hbkd: assertion failed");

`endif

### sv/hbkd_pkg.sv
// Shared types and constants for the boot keyboard report differ.
// No dependencies.
`default_nettype none

package hbkd_pkg;

  localparam int KEY_W         = 8;
  localparam int MOD_BITS      = 8;
  localparam int IN_SLOTS      = 6;
  localparam int KEY_SLOTS_DEF = 6;

  typedef logic [KEY_W-1:0] key_t;

  // Modifier bit n reports as usage 224 + n.
  localparam key_t MOD_CODE_BASE = 8'd224;
  // Usages below this never cause an event.
  localparam key_t LOWEST_KEY    = 8'd4;

  typedef struct packed {
    key_t code;
    logic press;
  } ev_t;

endpackage

`default_nettype wire

### sv/hbkd_in_if.sv
// Report request channel: valid/ready plus one boot keyboard report.
// Depends on hbkd_pkg.
`default_nettype none

interface hbkd_in_if;
  logic               valid;
  logic               ready;
  logic               report_ok;
  logic [7:0]         modifier_bits;
  hbkd_pkg::key_t     key_0;
  hbkd_pkg::key_t     key_1;
  hbkd_pkg::key_t     key_2;
  hbkd_pkg::key_t     key_3;
  hbkd_pkg::key_t     key_4;
  hbkd_pkg::key_t     key_5;

  modport source (
    output valid, report_ok, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
    input  ready
  );
  modport sink (
    input  valid, report_ok, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
    output ready
  );
endinterface

`default_nettype wire

### sv/hbkd_out_if.sv
// Key event request channel: valid/ready plus one key event.
// Depends on hbkd_pkg.
`default_nettype none

interface hbkd_out_if;
  logic           valid;
  logic           ready;
  hbkd_pkg::key_t key_code;
  logic           is_press;
  logic           last_event;

  modport source (output valid, key_code, is_press, last_event, input ready);
  modport sink   (input valid, key_code, is_press, last_event, output ready);
endinterface

`default_nettype wire

### sv/hbkd_diff.sv
// Input register, previous-report state and the compare logic that builds
// the candidate event list. Depends on hbkd_pkg and hbkd_in_if.
`default_nettype none

module hbkd_diff #(
  parameter  int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF,
  localparam int NEV       = hbkd_pkg::MOD_BITS + 2 * KEY_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  hbkd_in_if.sink          in_rpt,
  output logic             ev_valid,
  input  logic             ev_ready,
  output logic [NEV-1:0]   ev_mask,
  output hbkd_pkg::ev_t    ev_list [NEV]
);

  logic                    a_valid_r;
  logic                    a_ok_r;
  logic [7:0]              a_mods_r;
  hbkd_pkg::key_t          a_keys_r  [hbkd_pkg::IN_SLOTS];
  logic [7:0]              prev_mods_r;
  hbkd_pkg::key_t          prev_keys_r [KEY_SLOTS];
  hbkd_pkg::key_t          new_keys  [KEY_SLOTS];
  logic                    in_hs;
  logic                    any_ev;
  logic                    a_take;

  assign in_hs = in_rpt.valid && in_rpt.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_rpt.ready) begin
      a_valid_r <= in_rpt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      a_ok_r      <= in_rpt.report_ok;
      a_mods_r    <= in_rpt.modifier_bits;
      a_keys_r[0] <= in_rpt.key_0;
      a_keys_r[1] <= in_rpt.key_1;
      a_keys_r[2] <= in_rpt.key_2;
      a_keys_r[3] <= in_rpt.key_3;
      a_keys_r[4] <= in_rpt.key_4;
      a_keys_r[5] <= in_rpt.key_5;
    end
  end

  // Slots past the physical six read as zero.
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_new
    if (g < hbkd_pkg::IN_SLOTS) begin : g_phys
      assign new_keys[g] = a_keys_r[g];
    end else begin : g_pad
      assign new_keys[g] = '0;
    end
  end

  // Modifier events: one per changed bit, press if the bit is now set.
  for (genvar m = 0; m < hbkd_pkg::MOD_BITS; m++) begin : g_mod
    assign ev_mask[m]       = a_mods_r[m] ^ prev_mods_r[m];
    assign ev_list[m].code  = hbkd_pkg::MOD_CODE_BASE + hbkd_pkg::key_t'(m);
    assign ev_list[m].press = a_mods_r[m];
  end

  // Per slot: release of the old key, then press of the new key.
  for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_slot
    logic old_kept;
    logic new_known;

    always_comb begin
      old_kept  = 1'b0;
      new_known = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        old_kept  = old_kept  | (new_keys[j] == prev_keys_r[s]);
        new_known = new_known | (prev_keys_r[j] == new_keys[s]);
      end
    end

    assign ev_mask[hbkd_pkg::MOD_BITS + 2*s] =
      (prev_keys_r[s] >= hbkd_pkg::LOWEST_KEY) && !old_kept;
    assign ev_list[hbkd_pkg::MOD_BITS + 2*s].code  = prev_keys_r[s];
    assign ev_list[hbkd_pkg::MOD_BITS + 2*s].press = 1'b0;

    assign ev_mask[hbkd_pkg::MOD_BITS + 2*s + 1] =
      (new_keys[s] >= hbkd_pkg::LOWEST_KEY) && !new_known;
    assign ev_list[hbkd_pkg::MOD_BITS + 2*s + 1].code  = new_keys[s];
    assign ev_list[hbkd_pkg::MOD_BITS + 2*s + 1].press = 1'b1;
  end

  // Bad reports and reports with no change drain without using the emitter.
  assign any_ev        = |ev_mask;
  assign ev_valid      = a_valid_r && a_ok_r && any_ev;
  assign a_take        = a_valid_r && (!a_ok_r || !any_ev || ev_ready);
  assign in_rpt.ready  = !a_valid_r || a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mods_r <= '0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        prev_keys_r[k] <= '0;
      end
    end else if (a_take && a_ok_r) begin
      prev_mods_r <= a_mods_r;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        prev_keys_r[k] <= new_keys[k];
      end
    end
  end

endmodule

`default_nettype wire

### sv/hbkd_emit.sv
// Event list register and serializer: hands out the pending events lowest
// index first, one per cycle unless out_evt stalls, through an output register.
// Depends on hbkd_pkg and hbkd_out_if.
`default_nettype none

module hbkd_emit #(
  parameter  int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF,
  localparam int NEV       = hbkd_pkg::MOD_BITS + 2 * KEY_SLOTS,
  localparam int EVW       = $bits(hbkd_pkg::ev_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_valid,
  output logic             ev_ready,
  input  logic [NEV-1:0]   ev_mask,
  input  hbkd_pkg::ev_t    ev_list [NEV],
  hbkd_out_if.source       out_evt
);

  logic [NEV-1:0]   b_mask_r;
  logic [NEV-1:0]   b_mask_nxt;
  hbkd_pkg::ev_t    b_list_r [NEV];
  logic [NEV-1:0]   pick;
  logic [NEV-1:0]   rest;
  logic [EVW-1:0]   sel_bits;
  hbkd_pkg::ev_t    sel;
  logic             out_load;
  logic             b_load;
  logic             out_valid_r;
  logic             out_valid_nxt;
  hbkd_pkg::key_t   out_code_r;
  logic             out_press_r;
  logic             out_last_r;

  // Lowest pending event, one-hot.
  assign pick = b_mask_r & (~b_mask_r + {{(NEV-1){1'b0}}, 1'b1});
  assign rest = b_mask_r & ~pick;

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < NEV; i++) begin
      sel_bits = sel_bits | ({EVW{pick[i]}} & b_list_r[i]);
    end
  end
  assign sel = hbkd_pkg::ev_t'(sel_bits);

  assign out_load = (|b_mask_r) && (!out_valid_r || out_evt.ready);
  assign ev_ready = !(|b_mask_r) || (out_load && !(|rest));
  assign b_load   = ev_valid && ev_ready;

  always_comb begin
    priority if (b_load) begin
      b_mask_nxt = ev_mask;
    end else if (out_load) begin
      b_mask_nxt = rest;
    end else begin
      b_mask_nxt = b_mask_r;
    end
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_evt.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_mask_r    <= b_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int i = 0; i < NEV; i++) begin
        b_list_r[i] <= ev_list[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r  <= sel.code;
      out_press_r <= sel.press;
      out_last_r  <= !(|rest);
    end
  end

  assign out_evt.valid      = out_valid_r;
  assign out_evt.key_code   = out_code_r;
  assign out_evt.is_press   = out_press_r;
  assign out_evt.last_event = out_last_r;

endmodule

`default_nettype wire

### sv/hid_boot_keyboard_report_diff_unit.sv
// Boot keyboard report differ, top level. Depends on hbkd_pkg, the channel
// interfaces, hbkd_diff and hbkd_emit.
// The first event of a report passes the report, event list and output registers
// to reach out_evt. Throughput: one event per cycle while out_evt is ready; each
// report's events hold the emitter, one with none (or flagged bad) skips it.
// Reset (synchronous, rst_n low) empties both stages and zeroes the previous report.
`default_nettype none

module hid_boot_keyboard_report_diff_unit #(
  // Number of key slots kept as previous state; slots past six read as zero.
  parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hbkd_in_if.sink     in_rpt,
  hbkd_out_if.source  out_evt
);

  localparam int NEV = hbkd_pkg::MOD_BITS + 2 * KEY_SLOTS;

  // Candidate event list between the two stages. Bit order is the emit
  // order: modifiers 0..7, then per slot release-old followed by press-new.
  logic              ev_valid;
  logic              ev_ready;
  logic [NEV-1:0]    ev_mask;
  hbkd_pkg::ev_t     ev_list [NEV];

  // Stage one: report register and compare against the previous report.
  // The previous report is replaced when the registered report moves on,
  // so the next report compares against it without a gap. A bad report drops
  // here, never waits on the emitter, and leaves the previous report alone.
  hbkd_diff #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_rpt   (in_rpt),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev_mask  (ev_mask),
    .ev_list  (ev_list)
  );

  // Stage two: holds the pending mask and pops the lowest set bit each
  // cycle into the output register unless out_evt stalls. It takes the next list
  // in the same cycle its last event moves out, so reports stream without bubbles.
  hbkd_emit #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev_mask  (ev_mask),
    .ev_list  (ev_list),
    .out_evt  (out_evt)
  );

endmodule

`default_nettype wire

### sv/hbkd_checker.sv
// Port-level checker for the report differ, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hbkd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] key_code,
  input logic       is_press,
  input logic       last_event
);

  logic [9:0] payload;

  assign payload = {key_code, is_press, last_event};

  // Reset leaves no event request standing.
  `HBKD_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid)

  // A stalled event request holds its payload.
  `HBKD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(payload))

  // Usages 0..3 are never reported.
  `HBKD_ASSERT(a_no_low_code, clk, rst_n, out_valid |-> key_code >= 8'd4)

  // Back-pressure on reports only comes from events already on the way out.
  `HBKD_ASSERT(a_stall_has_events, clk, rst_n, !in_ready |=> out_valid)

  // A report's events come out without gaps up to its last one.
  `HBKD_ASSERT(a_burst_contig, clk, rst_n, out_valid && out_ready && !last_event |=> out_valid)

endmodule

bind hid_boot_keyboard_report_diff_unit hbkd_checker u_hbkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_rpt.ready),
  .out_valid  (out_evt.valid),
  .out_ready  (out_evt.ready),
  .key_code   (out_evt.key_code),
  .is_press   (out_evt.is_press),
  .last_event (out_evt.last_event)
);

`default_nettype wire

### sim/tb.sv
// Testbench for hid_boot_keyboard_report_diff_unit: directed and random report streams
// with a built-in predictor of the key event sequence. Depends on hbkd_pkg,
// hbkd_in_if, hbkd_out_if and the unit itself.
`timescale 1ns / 100ps

module tb;

  // Worst case is about 130 reports x 20 events, each slowed by receiver stalls;
  // this is far above that and still short.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES = 400;
  // Cycles to wait after the last event: the unit's latency plus margin.
  localparam int TAIL_CYCLES = 8;

  typedef hbkd_pkg::key_t slots_t [hbkd_pkg::IN_SLOTS];

  // One boot keyboard report as offered on the request channel.
  typedef struct {
    logic       ok;
    logic [7:0] mods;
    slots_t     keys;
  } report_t;

  // One predicted key event, with the end-of-report marker.
  typedef struct packed {
    hbkd_pkg::ev_t ev;
    logic          is_last;
  } key_event_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hbkd_in_if  in_rpt ();
  hbkd_out_if out_evt ();

  hid_boot_keyboard_report_diff_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rpt  (in_rpt),
    .out_evt (out_evt)
  );

  // Predictor state: the last accepted report.
  logic [7:0] held_mods = '0;
  slots_t     held_keys = '{default: '0};

  // Key events still owed by the unit, oldest first.
  key_event_t pending_events[$];

  int   err_count     = 0;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_on       = 1'b0;
  event hold_kick;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[hid_boot_keyboard_report_diff_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit slot_has(slots_t slots, hbkd_pkg::key_t code);
    foreach (slots[i])
      if (slots[i] == code)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_event(hbkd_pkg::key_t code, logic press);
    key_event_t e;
    e.ev.code  = code;
    e.ev.press = press;
    e.is_last  = 1'b0;
    pending_events.push_back(e);
  endfunction

  // Works out the events one accepted report causes and updates the state.
  function automatic void diff_report(report_t r);
    int n;
    n = 0;
    // Discarded report: no events, state left alone.
    if (!r.ok)
      return;
    // Modifiers first, bit 0 up: release on a falling bit, press on a rising one.
    for (int b = 0; b < hbkd_pkg::MOD_BITS; b++) begin
      if (held_mods[b] && !r.mods[b]) begin
        push_event(hbkd_pkg::MOD_CODE_BASE + hbkd_pkg::key_t'(b), 1'b0);
        n++;
      end
      if (r.mods[b] && !held_mods[b]) begin
        push_event(hbkd_pkg::MOD_CODE_BASE + hbkd_pkg::key_t'(b), 1'b1);
        n++;
      end
    end
    // Then each slot: old key out if gone from all new slots, new key in if it
    // was in no old slot. Each slot judged alone, so duplicates repeat.
    for (int s = 0; s < hbkd_pkg::IN_SLOTS; s++) begin
      if (held_keys[s] >= hbkd_pkg::LOWEST_KEY && !slot_has(r.keys, held_keys[s])) begin
        push_event(held_keys[s], 1'b0);
        n++;
      end
      if (r.keys[s] >= hbkd_pkg::LOWEST_KEY && !slot_has(held_keys, r.keys[s])) begin
        push_event(r.keys[s], 1'b1);
        n++;
      end
    end
    if (n > 0)
      pending_events[pending_events.size() - 1].is_last = 1'b1;
    held_mods = r.mods;
    held_keys = r.keys;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one report, after idle cycles drawn one by one, and returns in the
  // time step of the rising edge at which the unit takes it.
  task automatic send_report(input report_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_rpt.valid <= 1'b0;
      @(posedge clk);
    end
    in_rpt.valid         <= 1'b1;
    in_rpt.report_ok     <= r.ok;
    in_rpt.modifier_bits <= r.mods;
    in_rpt.key_0         <= r.keys[0];
    in_rpt.key_1         <= r.keys[1];
    in_rpt.key_2         <= r.keys[2];
    in_rpt.key_3         <= r.keys[3];
    in_rpt.key_4         <= r.keys[4];
    in_rpt.key_5         <= r.keys[5];
    @(posedge clk);
    while (!in_rpt.ready)
      @(posedge clk);
    diff_report(r);
  endtask

  function automatic report_t make_report(logic ok, logic [7:0] mods, int k0, int k1,
                                          int k2, int k3, int k4, int k5);
    report_t r;
    r.ok   = ok;
    r.mods = mods;
    r.keys = '{hbkd_pkg::key_t'(k0), hbkd_pkg::key_t'(k1), hbkd_pkg::key_t'(k2),
               hbkd_pkg::key_t'(k3), hbkd_pkg::key_t'(k4), hbkd_pkg::key_t'(k5)};
    return r;
  endfunction

  // Mostly a small pool of usages so keys collide between reports; now and
  // then the ignored codes or the full byte range.
  function automatic hbkd_pkg::key_t pick_key();
    case ($urandom_range(9))
      0:       return hbkd_pkg::key_t'($urandom_range(3));
      1, 2:    return hbkd_pkg::key_t'($urandom_range(255));
      default: return hbkd_pkg::key_t'($urandom_range(4, 24));
    endcase
  endfunction

  // A plausible next report: a few edits to the previous one, as a real
  // keyboard would send while keys go up and down.
  function automatic report_t next_report(report_t prev);
    report_t        r;
    int             a;
    int             b;
    hbkd_pkg::key_t k;
    r    = prev;
    r.ok = 1'b1;
    repeat ($urandom_range(1, 3)) begin
      a = $urandom_range(hbkd_pkg::IN_SLOTS - 1);
      b = $urandom_range(hbkd_pkg::IN_SLOTS - 1);
      case ($urandom_range(5))
        0:       r.mods = r.mods ^ (8'd1 << $urandom_range(7));
        1, 2:    r.keys[a] = pick_key();
        3:       r.keys[a] = '0;
        4: begin
          // key moves to another slot: no event for it
          k         = r.keys[a];
          r.keys[a] = r.keys[b];
          r.keys[b] = k;
        end
        default: r.keys[a] = r.keys[b];
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver readiness; forced low during a hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_evt.ready <= 1'b0;
    end else begin
      out_evt.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long hold-off, timed in its own process.
  always begin
    @(hold_kick);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Compare every taken key event with the oldest prediction.
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_evt.valid && out_evt.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected key event: key_code %0d is_press %0b last_event %0b",
               out_evt.key_code, out_evt.is_press, out_evt.last_event);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_evt.key_code !== want.ev.code) begin
          $error("key_code: expected %0d, got %0d", want.ev.code, out_evt.key_code);
          err_count++;
        end
        if (out_evt.is_press !== want.ev.press) begin
          $error("is_press: expected %0b, got %0b", want.ev.press, out_evt.is_press);
          err_count++;
        end
        if (out_evt.last_event !== want.is_last) begin
          $error("last_event: expected %0b, got %0b", want.is_last, out_evt.last_event);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-zero report right after reset, then the same again: nothing to say.
  task automatic test_quiet_reports();
    send_report(make_report(1'b1, 8'h00, 0, 0, 0, 0, 0, 0));
    send_report(make_report(1'b1, 8'h00, 0, 0, 0, 0, 0, 0));
  endtask

  // Every modifier rises together, falls together, then a checkerboard.
  task automatic test_modifier_edges();
    send_report(make_report(1'b1, 8'hFF, 0, 0, 0, 0, 0, 0));
    send_report(make_report(1'b1, 8'h00, 0, 0, 0, 0, 0, 0));
    send_report(make_report(1'b1, 8'h55, 0, 0, 0, 0, 0, 0));
    send_report(make_report(1'b1, 8'hAA, 0, 0, 0, 0, 0, 0));
  endtask

  // Full slots, same report again, same keys shuffled, byte extremes and the
  // ignored usages 0..3; usages 224+ in a key slot are plain keys.
  task automatic test_key_slots();
    send_report(make_report(1'b1, 8'h00, 4, 5, 6, 7, 8, 9));
    send_report(make_report(1'b1, 8'h00, 4, 5, 6, 7, 8, 9));
    send_report(make_report(1'b1, 8'h00, 9, 8, 7, 6, 5, 4));
    send_report(make_report(1'b1, 8'h80, 0, 1, 2, 3, 255, 254));
    send_report(make_report(1'b1, 8'h01, 3, 2, 1, 0, 0, 0));
    send_report(make_report(1'b1, 8'h01, 224, 231, 0, 0, 0, 0));
  endtask

  // A bad report changes nothing: resending the held report stays silent.
  task automatic test_discarded_report();
    send_report(make_report(1'b0, 8'hFE, 255, 128, 64, 32, 16, 8));
    send_report(make_report(1'b1, 8'h01, 224, 231, 0, 0, 0, 0));
  endtask

  // A key held in three slots presses three times and releases three times.
  task automatic test_repeated_keys();
    send_report(make_report(1'b1, 8'h00, 30, 30, 0, 30, 0, 0));
    send_report(make_report(1'b1, 8'h00, 31, 0, 0, 0, 0, 0));
  endtask

  // Twenty events in each middle report: every modifier flips and all twelve keys change.
  task automatic test_event_burst();
    send_report(make_report(1'b1, 8'h00, 4, 5, 6, 7, 8, 9));
    send_report(make_report(1'b1, 8'hFF, 10, 11, 12, 13, 14, 15));
    send_report(make_report(1'b1, 8'h00, 4, 5, 6, 7, 8, 9));
    send_report(make_report(1'b1, 8'h00, 0, 0, 0, 0, 0, 0));
  endtask

  // Receiver blocked for a long stretch while twenty-event reports keep
  // coming; the unit must fill up and hold its input ready low.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_kick;
    for (int i = 0; i < 12; i++) begin
      if (i[0])
        send_report(make_report(1'b1, 8'hFF, 10, 11, 12, 13, 14, 15));
      else
        send_report(make_report(1'b1, 8'h00, 4, 5, 6, 7, 8, 9));
    end
  endtask

  // Mostly edited copies of the last good report; some fully random ones,
  // some flagged bad.
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    report_t last_good;
    report_t r;
    int      sel;
    send_idle_pct  = s_pct;
    recv_idle_pct  = r_pct;
    last_good.ok   = 1'b1;
    last_good.mods = held_mods;
    last_good.keys = held_keys;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      if (sel < 2) begin
        r.ok   = (sel == 0);
        r.mods = 8'($urandom_range(255));
        foreach (r.keys[j])
          r.keys[j] = hbkd_pkg::key_t'($urandom_range(255));
      end else begin
        r = next_report(last_good);
        if (sel == 2)
          r.ok = 1'b0;
      end
      send_report(r);
      if (r.ok)
        last_good = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_rpt.valid         = 1'b0;
    in_rpt.report_ok     = 1'b0;
    in_rpt.modifier_bits = '0;
    in_rpt.key_0         = '0;
    in_rpt.key_1         = '0;
    in_rpt.key_2         = '0;
    in_rpt.key_3         = '0;
    in_rpt.key_4         = '0;
    in_rpt.key_5         = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quiet_reports();
    test_modifier_edges();
    test_key_slots();
    test_discarded_report();
    test_repeated_keys();
    test_event_burst();
    test_backpressure();
    test_random_traffic(35, 32, 78);
    test_random_traffic(35, 78, 32);
    test_random_traffic(30, 0, 0);

    // Drain: every owed event out, then TAIL_CYCLES more for strays.
    in_rpt.valid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("[hid_boot_keyboard_report_diff_unit] OK");
    else
      $display("[hid_boot_keyboard_report_diff_unit] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/hbkd_pkg.sv
sv/hbkd_in_if.sv
sv/hbkd_out_if.sv
sv/hbkd_diff.sv
sv/hbkd_emit.sv
sv/hid_boot_keyboard_report_diff_unit.sv
sv/hbkd_checker.sv
sim/tb.sv
